// ===== sv/plf_pkg.sv =====
// ============================================================================
// plf_pkg
// Shared types and constants for the five-level priority FIFO.
// ============================================================================
package plf_pkg;

    localparam int LEVELS              = 5;
    localparam int LEVEL_W             = 3;
    localparam int SLOTS_PER_LEVEL_DEF = 16;
    localparam int ITEM_BITS_DEF       = 32;
    localparam int IN_ITEM_W           = 32;
    localparam int OUT_ITEM_W          = 32;
    localparam int S_TDATA_W           = 40;
    localparam int M_TDATA_W           = 40;

    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BAD_PRIO = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_ZERO     = 3'd4
    } status_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic load_read;
    } plf_cmd_t;

    typedef struct packed {
        logic out_free;
        logic is_get;
        logic found;
    } plf_sts_t;

endpackage

// ===== sv/plf_ctrl.sv =====
// ============================================================================
// plf_ctrl
// Sequencer: takes one word, runs it through the datapath, releases the port.
// ============================================================================
module plf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  plf_pkg::plf_sts_t  sts,
    output plf_pkg::plf_cmd_t  cmd
);
    import plf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RDATA
    } state_t;

    state_t state_reg, state_next;
    logic   rdy_reg, rdy_next;

    always_comb begin
        state_next = state_reg;
        rdy_next   = rdy_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && rdy_reg) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                    rdy_next    = 1'b0;
                end else begin
                    rdy_next = 1'b1;
                end
            end
            S_EXEC: begin
                if (sts.out_free) begin
                    cmd.execute = 1'b1;
                    if (sts.is_get && sts.found) begin
                        state_next = S_RDATA;
                    end else begin
                        state_next = S_IDLE;
                        rdy_next   = 1'b1;
                    end
                end
            end
            S_RDATA: begin
                cmd.load_read = 1'b1;
                state_next    = S_IDLE;
                rdy_next      = 1'b1;
            end
            default: begin
                state_next = S_IDLE;
                rdy_next   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rdy_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            rdy_reg   <= rdy_next;
        end
    end

    assign s_tready = rdy_reg;

endmodule

// ===== sv/plf_dpath.sv =====
// ============================================================================
// plf_dpath
// Ring pointers, slot memory, level select and the result register.
// ============================================================================
module plf_dpath #(
    parameter int SLOTS_PER_LEVEL = plf_pkg::SLOTS_PER_LEVEL_DEF,
    parameter int ITEM_BITS       = plf_pkg::ITEM_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_op,
    input  logic [plf_pkg::IN_ITEM_W-1:0]    in_item,
    input  logic [plf_pkg::LEVEL_W-1:0]      in_level,
    input  plf_pkg::plf_cmd_t                cmd,
    output plf_pkg::plf_sts_t                sts,
    input  logic                             m_tready,
    output logic                             out_valid,
    output plf_pkg::status_t                 out_status,
    output logic [plf_pkg::OUT_ITEM_W-1:0]   out_item,
    output logic [plf_pkg::LEVEL_W-1:0]      out_level
);
    import plf_pkg::*;

    localparam int PTR_W  = (SLOTS_PER_LEVEL > 1) ? $clog2(SLOTS_PER_LEVEL) : 1;
    localparam int DEPTH  = LEVELS * SLOTS_PER_LEVEL;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(SLOTS_PER_LEVEL - 1);
    localparam logic [ADDR_W-1:0] SLOTS_A  = ADDR_W'(SLOTS_PER_LEVEL);
    localparam logic [LEVEL_W-1:0] LEVELS_L = LEVEL_W'(LEVELS);

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // captured request
    logic                 op_reg;
    logic [ITEM_BITS-1:0] item_reg;
    logic [LEVEL_W-1:0]   lvl_reg;

    logic [PTR_W-1:0] head_reg [LEVELS];
    logic [PTR_W-1:0] tail_reg [LEVELS];

    logic [ITEM_BITS-1:0] mem [DEPTH];
    logic [ITEM_BITS-1:0] rd_data_reg;
    logic [LEVEL_W-1:0]   hit_lvl_reg;

    logic                 valid_reg;
    status_t              status_reg;
    logic [OUT_ITEM_W-1:0] item_out_reg;
    logic [LEVEL_W-1:0]   level_out_reg;

    logic [LEVELS-1:0]  empty_v, full_v;
    logic               found;
    logic [LEVEL_W-1:0] found_lvl;
    logic               lvl_ok;
    logic [LEVEL_W-1:0] lvl_idx;
    logic [PTR_W-1:0]   tail_sel, head_sel;
    status_t            put_status;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [63:0]        in_wide, rd_wide;
    logic               out_free;

    always_comb begin
        for (int l = 0; l < LEVELS; l++) begin
            empty_v[l] = (head_reg[l] == tail_reg[l]);
            full_v[l]  = (ring_next(tail_reg[l]) == head_reg[l]);
        end
    end

    // fixed priority encoder, level 0 wins
    always_comb begin
        found     = 1'b0;
        found_lvl = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (!empty_v[l]) begin
                found     = 1'b1;
                found_lvl = LEVEL_W'(l);
            end
        end
    end

    assign lvl_ok   = (lvl_reg < LEVELS_L);
    assign lvl_idx  = lvl_ok ? lvl_reg : '0;
    assign tail_sel = tail_reg[lvl_idx];
    assign head_sel = head_reg[found_lvl];

    always_comb begin
        if (!lvl_ok) begin
            put_status = ST_BAD_PRIO;
        end else if (full_v[lvl_idx]) begin
            put_status = ST_FULL;
        end else if (item_reg == '0) begin
            put_status = ST_ZERO;
        end else begin
            put_status = ST_OK;
        end
    end

    assign wr_addr = ADDR_W'(lvl_idx) * SLOTS_A + ADDR_W'(tail_sel);
    assign rd_addr = ADDR_W'(found_lvl) * SLOTS_A + ADDR_W'(head_sel);
    assign in_wide = 64'(in_item);
    assign rd_wide = 64'(rd_data_reg);
    assign out_free = !valid_reg || m_tready;

    assign sts.out_free = out_free;
    assign sts.is_get   = (op_reg == OP_GET);
    assign sts.found    = found;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= in_op;
            item_reg <= in_wide[ITEM_BITS-1:0];
            lvl_reg  <= in_level;
        end
    end

    // slot memory
    always_ff @(posedge aclk) begin
        if (cmd.execute && (op_reg == OP_PUT) && (put_status == ST_OK)) begin
            mem[wr_addr] <= item_reg;
        end
        if (cmd.execute && (op_reg == OP_GET) && found) begin
            rd_data_reg <= mem[rd_addr];
            hit_lvl_reg <= found_lvl;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < LEVELS; l++) begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
            end
        end else if (cmd.execute) begin
            if (op_reg == OP_PUT) begin
                if (put_status == ST_OK) begin
                    tail_reg[lvl_idx] <= ring_next(tail_sel);
                end
            end else if (found) begin
                head_reg[found_lvl] <= ring_next(head_sel);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.load_read || (cmd.execute && !((op_reg == OP_GET) && found))) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_read) begin
            status_reg    <= ST_OK;
            item_out_reg  <= rd_wide[OUT_ITEM_W-1:0];
            level_out_reg <= hit_lvl_reg;
        end else if (cmd.execute && !((op_reg == OP_GET) && found)) begin
            status_reg    <= (op_reg == OP_PUT) ? put_status : ST_EMPTY;
            item_out_reg  <= '0;
            level_out_reg <= '0;
        end
    end

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_item   = item_out_reg;
    assign out_level  = level_out_reg;

endmodule

// ===== sv/five_level_priority_fifo.sv =====
// ============================================================================
// five_level_priority_fifo
// Five ring FIFOs, one per priority level; get pops from the lowest-numbered nonempty level.
// ============================================================================
// Order: a put is captured, then executed into the result register; a get
// also takes the registered read of the single slot memory (S_RDATA) before
// its result is loaded. Only one word is in flight at a time.
// A waiting result does not block acceptance of the next word.
// Reset: synchronous, active low; clears ring pointers and handshake state.
// Slot memory is not cleared.
module five_level_priority_fifo #(
    parameter int SLOTS_PER_LEVEL = plf_pkg::SLOTS_PER_LEVEL_DEF,
    parameter int ITEM_BITS       = plf_pkg::ITEM_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [plf_pkg::S_TDATA_W-1:0]  s_tdata,  // item_value, priority_level
    input  logic [0:0]                     s_tuser,  // op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [plf_pkg::M_TDATA_W-1:0]  m_tdata   // status, out_item, out_level
);
    import plf_pkg::*;

    plf_cmd_t              cmd;
    plf_sts_t              sts;
    status_t               res_status;
    logic [OUT_ITEM_W-1:0] res_item;
    logic [LEVEL_W-1:0]    res_level;

    plf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    plf_dpath #(
        .SLOTS_PER_LEVEL (SLOTS_PER_LEVEL),
        .ITEM_BITS       (ITEM_BITS)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_op      (s_tuser[0]),
        .in_item    (s_tdata[IN_ITEM_W-1:0]),
        .in_level   (s_tdata[IN_ITEM_W +: LEVEL_W]),
        .cmd        (cmd),
        .sts        (sts),
        .m_tready   (m_tready),
        .out_valid  (m_tvalid),
        .out_status (res_status),
        .out_item   (res_item),
        .out_level  (res_level)
    );

    assign m_tdata = {(M_TDATA_W - 3 - OUT_ITEM_W - LEVEL_W)'(0),
                      res_level, res_item, res_status};

endmodule

// ===== sv/plf_checker.sv =====
// ============================================================================
// plf_checker
// Port-level checks on the five-level priority FIFO.
// ============================================================================
module plf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [plf_pkg::M_TDATA_W-1:0]  m_tdata
);
    import plf_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in flight");

    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != ST_OK) |-> (m_tdata[37:3] == '0))
        else $error("failed request carries item or level");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[37:35] < 3'd5) && (m_tdata[39:38] == 2'b00))
        else $error("result level out of range");

endmodule

bind five_level_priority_fifo plf_checker u_plf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/plf_dispatch_check.sv =====
`timescale 1ns / 1ps
// ============================================================================
// plf_dispatch_check
// Watches both stream channels of the five-level priority FIFO. Every
// accepted input word goes through a shadow copy of the five rings to give
// the expected response. Responses are compared field by field, in order.
// ============================================================================
module plf_dispatch_check
    import plf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // item_value, priority_level
    input  logic [0:0]            s_tuser,   // op
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // status, out_item, out_level
    output int                    mismatches,
    output int                    outstanding
);

    localparam int SLOTS = SLOTS_PER_LEVEL_DEF;
    localparam int PTR_W = $clog2(SLOTS);

    // status sits in the low bits, so it is declared last
    typedef struct packed {
        logic [LEVEL_W-1:0]    level;
        logic [OUT_ITEM_W-1:0] item;
        status_t               status;
    } resp_t;

    logic [ITEM_BITS_DEF-1:0] ring_mem [LEVELS][SLOTS];
    logic [PTR_W-1:0]         rd_ptr   [LEVELS];
    logic [PTR_W-1:0]         wr_ptr   [LEVELS];
    resp_t                    resp_q   [$];
    int                       err_cnt = 0;

    assign mismatches = err_cnt;

    initial outstanding = 0;

    function automatic logic [PTR_W-1:0] ring_advance(logic [PTR_W-1:0] p);
        return (p == PTR_W'(SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic resp_t schedule_op(logic op, logic [IN_ITEM_W-1:0] value,
                                          logic [LEVEL_W-1:0] lvl);
        resp_t                    r;
        logic [ITEM_BITS_DEF-1:0] v;
        int                       hit;
        int                       l;
        r.status = ST_OK;
        r.item   = '0;
        r.level  = '0;
        v        = value[ITEM_BITS_DEF-1:0];
        hit      = -1;
        if (op == OP_PUT) begin
            if (lvl >= LEVELS) begin
                r.status = ST_BAD_PRIO;
            end else if (ring_advance(wr_ptr[lvl]) == rd_ptr[lvl]) begin
                r.status = ST_FULL;
            end else if (v == '0) begin
                r.status = ST_ZERO;
            end else begin
                ring_mem[lvl][wr_ptr[lvl]] = v;
                wr_ptr[lvl] = ring_advance(wr_ptr[lvl]);
            end
        end else begin
            // fixed priority: lowest nonempty level wins
            for (l = LEVELS - 1; l >= 0; l--) begin
                if (rd_ptr[l] != wr_ptr[l]) hit = l;
            end
            if (hit < 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.item  = OUT_ITEM_W'(ring_mem[hit][rd_ptr[hit]]);
                r.level = LEVEL_W'(hit);
                rd_ptr[hit] = ring_advance(rd_ptr[hit]);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        if (err_cnt < 40)
            $display("%0t ns: %s got 0x%0h, expected 0x%0h", $time, field, got, want);
        err_cnt++;
    endtask

    always @(posedge aclk) begin
        resp_t got;
        resp_t want;
        if (!aresetn) begin
            for (int l = 0; l < LEVELS; l++) begin
                rd_ptr[l] = '0;
                wr_ptr[l] = '0;
            end
            resp_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = resp_t'(m_tdata[$bits(resp_t)-1:0]);
                if (resp_q.size() == 0) begin
                    report_mismatch("response word with none pending, status",
                                    got.status, '0);
                end else begin
                    want = resp_q.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.item !== want.item)
                        report_mismatch("out_item", got.item, want.item);
                    if (got.level !== want.level)
                        report_mismatch("out_level", got.level, want.level);
                end
            end
            if (s_tvalid && s_tready) begin
                resp_q.push_back(schedule_op(s_tuser[0], s_tdata[IN_ITEM_W-1:0],
                                             s_tdata[IN_ITEM_W +: LEVEL_W]));
            end
        end
        outstanding <= resp_q.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Stimulus and verdict for the five-level priority FIFO. A short directed
// pass covers empty gets, zero items, bad levels and priority order; then
// random fill, drain, mixed and noise phases drive rings to full and back
// to empty, with bursty input and a patterned output stall.
// ============================================================================
module testbench;
    import plf_pkg::*;

    localparam int WORD_TARGET = 1900;

    typedef enum {RX_OPEN, RX_RANDOM, RX_EVERY_THIRD, RX_CHOKED} rx_mode_t;
    typedef enum {PH_FILL, PH_DRAIN, PH_MIX, PH_NOISE} phase_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // item_value, priority_level
    logic [0:0]            s_tuser  = '0;   // op
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // status, out_item, out_level
    int                    mismatches;
    int                    outstanding;
    int                    words_sent = 0;
    rx_mode_t              rx_mode    = RX_OPEN;
    int                    rx_left    = 0;
    int                    rx_tick    = 0;

    always #5 aclk = ~aclk;

    five_level_priority_fifo uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    plf_dispatch_check chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 150);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_OPEN:        m_tready <= 1'b1;
            RX_RANDOM:      m_tready <= ($urandom_range(0, 3) != 0);
            RX_EVERY_THIRD: m_tready <= (rx_tick % 3 != 0);
            default:        m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_word(logic op, logic [IN_ITEM_W-1:0] value,
                             logic [LEVEL_W-1:0] lvl);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - IN_ITEM_W - LEVEL_W){1'b0}}, lvl, value};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic hold_sender(int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic wait_for_responses();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    function automatic logic [IN_ITEM_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return IN_ITEM_W'(1) << $urandom_range(0, IN_ITEM_W - 1);
            default: return $urandom();
        endcase
    endfunction

    initial begin
        phase_t             ph;
        int                 len;
        int                 burst;
        int                 put_pct;
        logic [LEVEL_W-1:0] target;
        logic [LEVEL_W-1:0] lvl;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty get, rejects, one item per level (two at level 4), drain past empty
        send_word(OP_GET, '0, '0);
        send_word(OP_PUT, '0, 3'd0);
        send_word(OP_PUT, 32'h0000_0005, 3'd5);
        send_word(OP_PUT, 32'hDEAD_BEEF, 3'd7);
        send_word(OP_PUT, '0, 3'd6);
        send_word(OP_PUT, 32'hFFFF_FFFF, 3'd4);
        send_word(OP_PUT, 32'h0000_0001, 3'd4);
        send_word(OP_PUT, 32'h8000_0000, 3'd0);
        send_word(OP_PUT, 32'hA5A5_A5A5, 3'd2);
        send_word(OP_PUT, 32'h5A5A_5A5A, 3'd1);
        send_word(OP_PUT, 32'h1234_5678, 3'd3);
        repeat (7) send_word(OP_GET, $urandom(), LEVEL_W'($urandom_range(0, 7)));
        wait_for_responses();

        burst = $urandom_range(1, 16);
        while (words_sent < WORD_TARGET) begin
            ph     = phase_t'($urandom_range(0, 3));
            len    = $urandom_range(10, 40);
            target = LEVEL_W'($urandom_range(0, LEVELS - 1));
            case (ph)
                PH_FILL:  put_pct = 88;
                PH_DRAIN: put_pct = 12;
                default:  put_pct = 50;
            endcase
            repeat (len) begin
                if ($urandom_range(0, 99) < put_pct) begin
                    if (ph == PH_NOISE)
                        lvl = LEVEL_W'($urandom_range(0, 7));
                    else if ($urandom_range(0, 19) == 0)
                        lvl = LEVEL_W'($urandom_range(LEVELS, 7));
                    else if (ph == PH_FILL && $urandom_range(0, 3) != 0)
                        lvl = target;
                    else
                        lvl = LEVEL_W'($urandom_range(0, LEVELS - 1));
                    send_word(OP_PUT, pick_value(), lvl);
                end else begin
                    send_word(OP_GET, $urandom(), LEVEL_W'($urandom_range(0, 7)));
                end
                burst--;
                if (burst == 0) begin
                    hold_sender($urandom_range(0, 6));
                    burst = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
                end
            end
            if ($urandom_range(0, 3) == 0) wait_for_responses();
        end

        wait_for_responses();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== five_level_priority_fifo.f =====
sv/plf_pkg.sv
sv/plf_ctrl.sv
sv/plf_dpath.sv
sv/five_level_priority_fifo.sv
sv/plf_checker.sv
test/plf_dispatch_check.sv
test/testbench.sv
